[sv/gcib_pkg.sv]
// gcib_pkg: shared constants, the arctangent table and the queue item type for the
// great-circle initial bearing block. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gcib_pkg;

	localparam int ANGLE_BITS   = 32;
	localparam int BEARING_BITS = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int TABLE_LEN    = 32;
	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// signed working angle, one bit above a turn
	localparam int ZW = ANGLE_BITS + 1;
	// sin/cos in q30 with cordic growth headroom
	localparam int CW = 34;
	// products and the vectoring datapath
	localparam int PW = 36;
	localparam int Q_FRAC = 30;
	localparam logic signed [CW-1:0] GAIN = CW'(652032874);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// 32-bit binary angle rescaled to ANGLE_BITS, low bits truncated
	function automatic logic [ANGLE_BITS-1:0] from32(input logic [31:0] a);
		logic [39:0] t;
		t = {a, 8'd0};
		return ANGLE_BITS'(t >> (40 - ANGLE_BITS));
	endfunction

	function automatic logic [ANGLE_BITS-1:0] atan_ang(input int i);
		return from32(ATAN_TURN32[i]);
	endfunction

	typedef struct packed {
		logic signed [ZW-1:0] z_lat1;
		logic signed [ZW-1:0] z_lat2;
		logic signed [ZW-1:0] z_dlon;
		logic [2:0]           flip;
	} item_t;

endpackage
`default_nettype wire

[sv/gcib_front.sv]
// gcib_front: accepts a request, forms the longitude difference and folds each angle
// into the cordic range. Depends on gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_front (
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] start_latitude,
	input  wire logic signed [31:0] start_longitude,
	input  wire logic signed [31:0] end_latitude,
	input  wire logic signed [31:0] end_longitude,
	input  wire logic               q_full,
	output logic                    push,
	output gcib_pkg::item_t         item
);

	localparam logic signed [gcib_pkg::ZW-1:0] QUARTER =
		gcib_pkg::ZW'(64'd1 << (gcib_pkg::ANGLE_BITS - 2));
	localparam logic signed [gcib_pkg::ZW-1:0] HALF =
		gcib_pkg::ZW'(64'd1 << (gcib_pkg::ANGLE_BITS - 1));

	typedef struct packed {
		logic signed [gcib_pkg::ZW-1:0] z;
		logic                           flip;
	} fold_t;

	function automatic fold_t fold(input logic [gcib_pkg::ANGLE_BITS-1:0] a);
		fold_t r;
		logic signed [gcib_pkg::ZW-1:0] zs;
		zs = signed'({a[gcib_pkg::ANGLE_BITS-1], a});
		r.flip = 1'b0;
		r.z = zs;
		if (zs > QUARTER) begin
			r.z = zs - HALF;
			r.flip = 1'b1;
		end else if (zs < -QUARTER) begin
			r.z = zs + HALF;
			r.flip = 1'b1;
		end
		return r;
	endfunction

	logic [31:0] dlon;
	fold_t f1, f2, fd;

	assign dlon = 32'(end_longitude) - 32'(start_longitude);
	assign f1 = fold(gcib_pkg::from32(32'(start_latitude)));
	assign f2 = fold(gcib_pkg::from32(32'(end_latitude)));
	assign fd = fold(gcib_pkg::from32(dlon));

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign item = '{z_lat1: f1.z, z_lat2: f2.z, z_dlon: fd.z, flip: {fd.flip, f2.flip, f1.flip}};

endmodule
`default_nettype wire

[sv/gcib_fifo.sv]
// gcib_fifo: short queue of folded requests between front and back.
// Depends on gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  gcib_pkg::item_t din,
	output logic            full,
	input  wire logic       pop,
	output gcib_pkg::item_t dout,
	output logic            not_empty
);

	gcib_pkg::item_t mem [gcib_pkg::FIFO_DEPTH];
	logic [gcib_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [gcib_pkg::FIFO_AW:0]   count_q;

	assign full = (count_q == (gcib_pkg::FIFO_AW+1)'(gcib_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign dout = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (gcib_pkg::FIFO_AW+1)'(gcib_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule
`default_nettype wire

[sv/gcib_back.sv]
// gcib_back: pipelined sin/cos cordics, the products, vectoring cordic and rounding.
// Depends on gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  gcib_pkg::item_t q_item,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [gcib_pkg::BEARING_BITS-1:0] bearing
);

	localparam int S  = gcib_pkg::STEPS;
	localparam int AB = gcib_pkg::ANGLE_BITS;
	localparam int BB = gcib_pkg::BEARING_BITS;
	localparam int CW = gcib_pkg::CW;
	localparam int PW = gcib_pkg::PW;
	localparam int ZW = gcib_pkg::ZW;

	logic adv;

	logic signed [CW-1:0] rx_s [3][S+1];
	logic signed [CW-1:0] ry_s [3][S+1];
	logic signed [ZW-1:0] rz_s [3][S+1];
	logic                 rf_s [3][S+1];
	logic [S:0]           rv_s;

	logic signed [CW-1:0] c1, s1, c2, s2, cd, sd;
	logic signed [PW-1:0] ym_s1, p1_s1, p2_s1;
	logic signed [CW-1:0] cd_s1;
	logic                 vm_s1;
	logic signed [PW-1:0] yv_s2, xv_s2;
	logic                 vm_s2;
	logic signed [2*CW-1:0] prod_y, prod_1, prod_2;
	logic signed [PW+CW-1:0] prod_3;

	logic signed [PW-1:0] ax_s [S+1];
	logic signed [PW-1:0] ay_s [S+1];
	logic [AB-1:0]        az_s [S+1];
	logic                 azero_s [S+1];
	logic [S:0]           av_s;

	logic [AB-1:0] ang;
	logic [BB-1:0] rounded;
	logic          valid_q;
	logic [BB-1:0] bearing_q;

	assign adv = !valid_q || !out_stall;
	assign pop = adv && q_valid;

	// undo the half-turn fold
	assign c1 = rf_s[0][S] ? -rx_s[0][S] : rx_s[0][S];
	assign s1 = rf_s[0][S] ? -ry_s[0][S] : ry_s[0][S];
	assign c2 = rf_s[1][S] ? -rx_s[1][S] : rx_s[1][S];
	assign s2 = rf_s[1][S] ? -ry_s[1][S] : ry_s[1][S];
	assign cd = rf_s[2][S] ? -rx_s[2][S] : rx_s[2][S];
	assign sd = rf_s[2][S] ? -ry_s[2][S] : ry_s[2][S];

	assign prod_y = sd * c2;
	assign prod_1 = c1 * s2;
	assign prod_2 = s1 * c2;
	assign prod_3 = p2_s1 * cd_s1;

	assign ang = azero_s[S] ? '0 : az_s[S];

	generate
		if (AB > BB) begin : g_round
			localparam int SH = AB - BB;
			logic [AB:0] sum;
			assign sum = {1'b0, ang} + ((AB+1)'(1) << (SH - 1));
			assign rounded = BB'(sum >> SH);
		end else begin : g_widen
			assign rounded = BB'(ang) << (BB - AB);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int u = 0; u < 3; u++) begin
				rx_s[u][0] <= gcib_pkg::GAIN;
				ry_s[u][0] <= '0;
				rf_s[u][0] <= q_item.flip[u];
			end
			rz_s[0][0] <= q_item.z_lat1;
			rz_s[1][0] <= q_item.z_lat2;
			rz_s[2][0] <= q_item.z_dlon;
			for (int i = 0; i < S; i++) begin
				for (int u = 0; u < 3; u++) begin
					rf_s[u][i+1] <= rf_s[u][i];
					if (!rz_s[u][i][ZW-1]) begin
						rx_s[u][i+1] <= rx_s[u][i] - (ry_s[u][i] >>> i);
						ry_s[u][i+1] <= ry_s[u][i] + (rx_s[u][i] >>> i);
						rz_s[u][i+1] <= rz_s[u][i] - signed'({1'b0, gcib_pkg::atan_ang(i)});
					end else begin
						rx_s[u][i+1] <= rx_s[u][i] + (ry_s[u][i] >>> i);
						ry_s[u][i+1] <= ry_s[u][i] - (rx_s[u][i] >>> i);
						rz_s[u][i+1] <= rz_s[u][i] + signed'({1'b0, gcib_pkg::atan_ang(i)});
					end
				end
			end

			// q30 products, floor shift
			ym_s1 <= PW'(prod_y >>> gcib_pkg::Q_FRAC);
			p1_s1 <= PW'(prod_1 >>> gcib_pkg::Q_FRAC);
			p2_s1 <= PW'(prod_2 >>> gcib_pkg::Q_FRAC);
			cd_s1 <= cd;

			yv_s2 <= ym_s1;
			xv_s2 <= p1_s1 - PW'(prod_3 >>> gcib_pkg::Q_FRAC);

			// move into the right half plane
			azero_s[0] <= (xv_s2 == '0) && (yv_s2 == '0);
			if (xv_s2[PW-1]) begin
				ax_s[0] <= -xv_s2;
				ay_s[0] <= -yv_s2;
				az_s[0] <= AB'(64'd1 << (AB - 1));
			end else begin
				ax_s[0] <= xv_s2;
				ay_s[0] <= yv_s2;
				az_s[0] <= '0;
			end
			for (int i = 0; i < S; i++) begin
				azero_s[i+1] <= azero_s[i];
				if (!ay_s[i][PW-1]) begin
					ax_s[i+1] <= ax_s[i] + (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] - (ax_s[i] >>> i);
					az_s[i+1] <= az_s[i] + gcib_pkg::atan_ang(i);
				end else begin
					ax_s[i+1] <= ax_s[i] - (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] + (ax_s[i] >>> i);
					az_s[i+1] <= az_s[i] - gcib_pkg::atan_ang(i);
				end
			end

			bearing_q <= rounded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= '0;
			vm_s1 <= 1'b0;
			vm_s2 <= 1'b0;
			av_s <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			rv_s <= {rv_s[S-1:0], q_valid};
			vm_s1 <= rv_s[S];
			vm_s2 <= vm_s1;
			av_s <= {av_s[S-1:0], vm_s2};
			valid_q <= av_s[S];
		end
	end

	assign out_valid = valid_q;
	assign bearing = bearing_q;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(rv_s) && $stable(av_s))
		else $error("pipeline moved while output held");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rv_s[0]) else $error("popped request lost at pipeline entry");
	a_no_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |-> !pop) else $error("pop while output held");

endmodule
`default_nettype wire

[sv/great_circle_initial_bearing.sv]
// Great-circle initial bearing: takes a start and end point as 32-bit binary angles and
// returns the forward azimuth as an unsigned 16-bit binary angle, one result per request.
// Throughput is one request per clock while out_stall is low; the two cordic chains are fully
// pipelined, and a four-entry queue sits in front.
// Depends on gcib_pkg, gcib_front, gcib_fifo and gcib_back.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_initial_bearing (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] start_latitude,
	input  wire logic signed [31:0] start_longitude,
	input  wire logic signed [31:0] end_latitude,
	input  wire logic signed [31:0] end_longitude,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [gcib_pkg::BEARING_BITS-1:0] bearing
);

	logic            push, q_full, pop, q_valid;
	gcib_pkg::item_t f_item, q_item;

	gcib_front u_front (
		.in_valid(in_valid), .in_stall(in_stall),
		.start_latitude(start_latitude), .start_longitude(start_longitude),
		.end_latitude(end_latitude), .end_longitude(end_longitude),
		.q_full(q_full), .push(push), .item(f_item)
	);

	gcib_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(f_item), .full(q_full),
		.pop(pop), .dout(q_item), .not_empty(q_valid)
	);

	gcib_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .bearing(bearing)
	);

endmodule
`default_nettype wire
